FILE: src/cctf_pkg.sv
// ----------------------------------------------------------------------------
// cctf_pkg: shared types, constants and functions of the character lexer
//
// Holds the table geometry, the slot and row layout, the controller states
// and the character class decoder.
// ----------------------------------------------------------------------------
package cctf_pkg;

  // Table geometry.
  localparam int NUM_STATES      = 64;
  localparam int SLOTS_PER_STATE = 16;
  localparam int STATE_W         = $clog2(NUM_STATES);
  localparam int SLOT_W          = $clog2(SLOTS_PER_STATE);

  // Field widths of a transaction.
  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int PATTERN_W = 8;
  localparam int ACTION_W  = 4;
  localparam int NEXT_W    = 6;

  // Patterns below this value name a character class.
  localparam logic [PATTERN_W-1:0] LITERAL_BASE = 8'd32;
  localparam logic [PATTERN_W-1:0] PAT_END      = 8'd0;

  // Transaction modes.
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHAR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // Character class numbers.
  localparam logic [PATTERN_W-1:0] CLS_IDENT_START = 8'd1;
  localparam logic [PATTERN_W-1:0] CLS_IDENT       = 8'd2;
  localparam logic [PATTERN_W-1:0] CLS_IDENT_DASH  = 8'd4;
  localparam logic [PATTERN_W-1:0] CLS_QUOTABLE    = 8'd9;
  localparam logic [PATTERN_W-1:0] CLS_DIGIT       = 8'd14;
  localparam logic [PATTERN_W-1:0] CLS_CR          = 8'd18;
  localparam logic [PATTERN_W-1:0] CLS_ALNUM       = 8'd19;
  localparam logic [PATTERN_W-1:0] CLS_LF          = 8'd20;
  localparam logic [PATTERN_W-1:0] CLS_BLANK       = 8'd23;
  localparam logic [PATTERN_W-1:0] CLS_PRINT_HI    = 8'd24;
  localparam logic [PATTERN_W-1:0] CLS_ALPHA       = 8'd25;

  // One transition slot and one table row.
  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [ACTION_W-1:0]  action;
    logic [NEXT_W-1:0]    next;
  } slot_t;

  typedef slot_t [SLOTS_PER_STATE-1:0] row_t;

  // Result of matching one character against one row.
  typedef struct packed {
    logic                found;
    logic [ACTION_W-1:0] action;
    logic [NEXT_W-1:0]   next;
  } match_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATCH
  } ctrl_state_e;

  // Returns 1 when byte c belongs to character class cls.
  function automatic logic class_match(logic [CHAR_W-1:0] c, logic [PATTERN_W-1:0] cls);
    logic alpha;
    logic digit;
    logic print;
    logic res;
    alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    digit = (c >= 8'h30 && c <= 8'h39);
    print = (c >= 8'h20 && c <= 8'h7E);
    case (cls)
      CLS_IDENT_START: res = alpha || (c == 8'h5F);
      CLS_IDENT:       res = alpha || digit || (c == 8'h5F);
      CLS_IDENT_DASH:  res = alpha || digit || (c == 8'h5F) || (c == 8'h2D);
      CLS_QUOTABLE:    res = print && (c != 8'h23) && (c != 8'h22);
      CLS_DIGIT:       res = digit;
      CLS_CR:          res = (c == 8'h0D);
      CLS_ALNUM:       res = alpha || digit;
      CLS_LF:          res = (c == 8'h0A);
      CLS_BLANK:       res = (c == 8'h20) || (c == 8'h09);
      CLS_PRINT_HI:    res = print || c[7] || (c == 8'h09);
      CLS_ALPHA:       res = alpha;
      default:         res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: src/cctf_row_match.sv
// ----------------------------------------------------------------------------
// cctf_row_match: first-match search over one transition table row
//
// Compares a byte against every slot of a row in parallel and picks the
// first slot that matches before the end-of-list marker.
// ----------------------------------------------------------------------------
module cctf_row_match (
  input  cctf_pkg::row_t             row_i,
  input  logic [cctf_pkg::CHAR_W-1:0] char_i,
  output cctf_pkg::match_t           match_o
);

  logic [cctf_pkg::SLOTS_PER_STATE-1:0] hit;
  logic [cctf_pkg::SLOTS_PER_STATE-1:0] live;

  // Per-slot compare: a class lookup or an exact byte compare.
  always_comb begin
    for (int i = 0; i < cctf_pkg::SLOTS_PER_STATE; i++) begin
      if (row_i[i].pattern == cctf_pkg::PAT_END) begin
        hit[i] = 1'b0;
      end else if (row_i[i].pattern < cctf_pkg::LITERAL_BASE) begin
        hit[i] = cctf_pkg::class_match(char_i, row_i[i].pattern);
      end else begin
        hit[i] = (char_i == row_i[i].pattern);
      end
    end
  end

  // A slot is live while no earlier slot ended the list.
  always_comb begin
    live[0] = 1'b1;
    for (int i = 1; i < cctf_pkg::SLOTS_PER_STATE; i++) begin
      live[i] = live[i-1] && (row_i[i-1].pattern != cctf_pkg::PAT_END);
    end
  end

  // Priority pick of the first live hit.
  always_comb begin
    match_o = '0;
    for (int i = cctf_pkg::SLOTS_PER_STATE - 1; i >= 0; i--) begin
      if (live[i] && hit[i]) begin
        match_o.found  = 1'b1;
        match_o.action = row_i[i].action;
        match_o.next   = row_i[i].next;
      end
    end
  end

endmodule

FILE: src/char_class_table_fsm.sv
// ----------------------------------------------------------------------------
// char_class_table_fsm: programmable table-driven character lexer
//
// Load and restart transactions are done in the idle state. A character
// transaction reads the current state's row from the table memory into a
// register, then matches the byte and updates the state; the next
// transaction is taken after that, and a result waiting in the output
// register holds the match step until it is taken. After reset the table
// memory is cleared one row a cycle, which keeps the input stalled until
// every row is cleared.
// ----------------------------------------------------------------------------
module char_class_table_fsm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cctf_pkg::MODE_W-1:0]       mode_i,
  input  logic [cctf_pkg::CHAR_W-1:0]       char_in_i,
  input  logic [5:0]                        entry_state_i,
  input  logic [3:0]                        entry_slot_i,
  input  logic [cctf_pkg::PATTERN_W-1:0]    entry_pattern_i,
  input  logic [cctf_pkg::ACTION_W-1:0]     entry_action_i,
  input  logic [cctf_pkg::NEXT_W-1:0]       entry_next_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cctf_pkg::ACTION_W-1:0]     action_out_o,
  output logic [cctf_pkg::NEXT_W-1:0]       next_state_out_o,
  output logic                              error_flag_o
);

  // Table memory, one row per state.
  cctf_pkg::row_t mem [cctf_pkg::NUM_STATES];

  cctf_pkg::ctrl_state_e state_q, state_d;
  logic [cctf_pkg::STATE_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [cctf_pkg::NEXT_W-1:0]  cur_state_q, cur_state_d;
  logic [cctf_pkg::CHAR_W-1:0]  char_q;
  cctf_pkg::row_t               rd_row_q;

  logic                         out_valid_q, out_valid_d;
  logic [cctf_pkg::ACTION_W-1:0] action_q;
  logic [cctf_pkg::NEXT_W-1:0]   next_q;
  logic                          error_q;

  logic          accept;
  logic          load_ok;
  logic          clr_we;
  logic          load_we;
  logic          rd_en;
  logic          res_we;
  logic          res_err;
  cctf_pkg::match_t match;

  assign accept  = in_valid_i && !in_stall_o;
  assign load_ok = (32'(entry_state_i) < cctf_pkg::NUM_STATES) &&
                   (32'(entry_slot_i) < cctf_pkg::SLOTS_PER_STATE);

  // Match the row registered by the read in the idle state.
  cctf_row_match u_match (
    .row_i   (rd_row_q),
    .char_i  (char_q),
    .match_o (match)
  );

  assign res_err = !match.found || (32'(match.next) >= cctf_pkg::NUM_STATES);

  // Controller: clearing pass, idle, match.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_state_d = cur_state_q;
    in_stall_o  = 1'b1;
    clr_we      = 1'b0;
    load_we     = 1'b0;
    rd_en       = 1'b0;
    res_we      = 1'b0;
    case (state_q)
      cctf_pkg::ST_CLEAR: begin
        clr_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (32'(clr_cnt_q) == cctf_pkg::NUM_STATES - 1) begin
          state_d = cctf_pkg::ST_IDLE;
        end
      end
      cctf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (mode_i)
            cctf_pkg::MODE_LOAD:    load_we = load_ok;
            cctf_pkg::MODE_RESTART: cur_state_d = '0;
            cctf_pkg::MODE_CHAR: begin
              rd_en   = 1'b1;
              state_d = cctf_pkg::ST_MATCH;
            end
            default: ;
          endcase
        end
      end
      cctf_pkg::ST_MATCH: begin
        if (!out_valid_q || !out_stall_i) begin
          res_we      = 1'b1;
          cur_state_d = res_err ? '0 : match.next;
          state_d     = cctf_pkg::ST_IDLE;
        end
      end
      default: state_d = cctf_pkg::ST_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (res_we) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cctf_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      cur_state_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_state_q <= cur_state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Table memory: clearing writes, slot loads and the row read.
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      mem[clr_cnt_q] <= '0;
    end else if (load_we) begin
      mem[entry_state_i[cctf_pkg::STATE_W-1:0]][entry_slot_i[cctf_pkg::SLOT_W-1:0]] <=
        {entry_pattern_i, entry_action_i, entry_next_i};
    end
    if (rd_en) begin
      rd_row_q <= mem[cur_state_q[cctf_pkg::STATE_W-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == cctf_pkg::MODE_CHAR)) begin
      char_q <= char_in_i;
    end
    if (res_we) begin
      action_q <= res_err ? '0 : match.action;
      next_q   <= res_err ? '0 : match.next;
      error_q  <= res_err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_out_o     = action_q;
  assign next_state_out_o = next_q;
  assign error_flag_o     = error_q;

endmodule

FILE: tb/tb_char_class_table_fsm.sv
// ----------------------------------------------------------------------------
// tb_char_class_table_fsm: self-checking testbench of the character lexer
//
// Loads transition slots, restarts and feeds bytes through the lexer. A
// behavioral copy of the slot table and the current state predicts the
// action, the next state and the error flag of every character
// transaction. The results are checked in order against that prediction
// while the input idles in random gaps and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_char_class_table_fsm;
  import cctf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 1750;
  localparam int DRAIN_CYCLES = 8;

  // One input transaction and one predicted result.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [CHAR_W-1:0]    ch;
    logic [STATE_W-1:0]   st;
    logic [SLOT_W-1:0]    sl;
    logic [PATTERN_W-1:0] pat;
    logic [ACTION_W-1:0]  act;
    logic [NEXT_W-1:0]    nxt;
  } lex_item_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [NEXT_W-1:0]   next;
    logic                err;
  } lex_result_t;

  // Block ports.
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [MODE_W-1:0]    mode_i          = '0;
  logic [CHAR_W-1:0]    char_in_i       = '0;
  logic [5:0]           entry_state_i   = '0;
  logic [3:0]           entry_slot_i    = '0;
  logic [PATTERN_W-1:0] entry_pattern_i = '0;
  logic [ACTION_W-1:0]  entry_action_i  = '0;
  logic [NEXT_W-1:0]    entry_next_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [ACTION_W-1:0]  action_out_o;
  logic [NEXT_W-1:0]    next_state_out_o;
  logic                 error_flag_o;

  // Stimulus queue, predicted results and the lexer's shadow state.
  lex_item_t   lex_items_q[$];
  lex_result_t lex_results_q[$];
  slot_t       lex_table [NUM_STATES][SLOTS_PER_STATE];
  logic [STATE_W-1:0] lex_state;
  logic [CHAR_W-1:0]  literal_bytes[$];

  int cycle_cnt    = 0;
  int mismatch_cnt = 0;
  int stim_cnt     = 0;
  int burst_left   = 4;
  int gap_left     = 0;
  int stall_mode   = 0;

  logic [CHAR_W-1:0] probe_chars [0:29] = '{
    8'h30, 8'h39, 8'h2F, 8'h3A, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61,
    8'h7A, 8'h7B, 8'h5F, 8'h2D, 8'h23, 8'h22, 8'h20, 8'h09, 8'h0D, 8'h0A,
    8'h1F, 8'h21, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h2C, 8'h2E, 8'h08
  };

  char_class_table_fsm DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .char_in_i       (char_in_i),
    .entry_state_i   (entry_state_i),
    .entry_slot_i    (entry_slot_i),
    .entry_pattern_i (entry_pattern_i),
    .entry_action_i  (entry_action_i),
    .entry_next_i    (entry_next_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_out_o    (action_out_o),
    .next_state_out_o(next_state_out_o),
    .error_flag_o    (error_flag_o)
  );

  // Clock generation.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Each mismatch prints one line and is counted.
  task automatic report_mismatch(string what);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // Class membership of a byte, following the lexer's class numbering.
  function automatic logic in_class(logic [CHAR_W-1:0] c, logic [PATTERN_W-1:0] cls);
    logic letter;
    logic num;
    logic visible;
    logic member;
    letter  = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    num     = (c >= "0" && c <= "9");
    visible = (c >= 8'h20 && c <= 8'h7E);
    case (cls)
      CLS_IDENT_START: member = letter | (c == "_");
      CLS_IDENT:       member = letter | num | (c == "_");
      CLS_IDENT_DASH:  member = letter | num | (c == "_") | (c == "-");
      CLS_QUOTABLE:    member = visible & (c != "#") & (c != 8'h22);
      CLS_DIGIT:       member = num;
      CLS_CR:          member = (c == 8'h0D);
      CLS_ALNUM:       member = letter | num;
      CLS_LF:          member = (c == 8'h0A);
      CLS_BLANK:       member = (c == " ") | (c == 8'h09);
      CLS_PRINT_HI:    member = visible | (c >= 8'h80) | (c == 8'h09);
      CLS_ALPHA:       member = letter;
      default:         member = 1'b0;
    endcase
    return member;
  endfunction

  // Applies one accepted transaction to the shadow lexer and queues the
  // result that a character transaction produces.
  function automatic void lex_predict(lex_item_t it);
    slot_t       s;
    lex_result_t r;
    logic        done;
    logic        hit;
    r    = '{action: '0, next: '0, err: 1'b1};
    done = 1'b0;
    case (it.mode)
      MODE_LOAD: begin
        lex_table[it.st][it.sl] = '{pattern: it.pat, action: it.act, next: it.nxt};
      end
      MODE_RESTART: begin
        lex_state = '0;
      end
      MODE_CHAR: begin
        // Scan the list in order; the end marker stops the scan.
        for (int i = 0; i < SLOTS_PER_STATE; i++) begin
          if (!done) begin
            s = lex_table[lex_state][i];
            if (s.pattern == PAT_END) begin
              done = 1'b1;
            end else begin
              hit = (s.pattern < LITERAL_BASE) ? in_class(it.ch, s.pattern)
                                               : (it.ch == s.pattern);
              if (hit) begin
                done = 1'b1;
                if (int'(s.next) < NUM_STATES) begin
                  r = '{action: s.action, next: s.next, err: 1'b0};
                end
              end
            end
          end
        end
        lex_state = r.next;
        lex_results_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Stimulus builders; fields a mode does not use get random values.
  function automatic void add_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                                   logic [STATE_W-1:0] st, logic [SLOT_W-1:0] sl,
                                   logic [PATTERN_W-1:0] pat, logic [ACTION_W-1:0] act,
                                   logic [NEXT_W-1:0] nxt);
    lex_items_q.push_back('{mode: mode, ch: ch, st: st, sl: sl, pat: pat, act: act,
                            nxt: nxt});
    if (mode != MODE_UNUSED) begin
      stim_cnt++;
    end
  endfunction

  function automatic void add_load(int st, int sl, logic [PATTERN_W-1:0] pat, int act,
                                   int nxt);
    if (pat >= LITERAL_BASE) begin
      literal_bytes.push_back(pat);
    end
    add_item(MODE_LOAD, CHAR_W'($urandom_range(0, 255)), STATE_W'(st), SLOT_W'(sl), pat,
             ACTION_W'(act), NEXT_W'(nxt));
  endfunction

  function automatic void add_char(logic [CHAR_W-1:0] ch);
    add_item(MODE_CHAR, ch, STATE_W'($urandom_range(0, 63)), SLOT_W'($urandom_range(0, 15)),
             PATTERN_W'($urandom_range(0, 255)), ACTION_W'($urandom_range(0, 15)),
             NEXT_W'($urandom_range(0, 63)));
  endfunction

  function automatic void add_ctrl(logic [MODE_W-1:0] mode);
    add_item(mode, CHAR_W'($urandom_range(0, 255)), STATE_W'($urandom_range(0, 63)),
             SLOT_W'($urandom_range(0, 15)), PATTERN_W'($urandom_range(0, 255)),
             ACTION_W'($urandom_range(0, 15)), NEXT_W'($urandom_range(0, 63)));
  endfunction

  // Mostly named classes, some unassigned class numbers, some literals.
  function automatic logic [PATTERN_W-1:0] rand_pattern();
    logic [PATTERN_W-1:0] p;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      case ($urandom_range(0, 10))
        0:       p = CLS_IDENT_START;
        1:       p = CLS_IDENT;
        2:       p = CLS_IDENT_DASH;
        3:       p = CLS_QUOTABLE;
        4:       p = CLS_DIGIT;
        5:       p = CLS_CR;
        6:       p = CLS_ALNUM;
        7:       p = CLS_LF;
        8:       p = CLS_BLANK;
        9:       p = CLS_PRINT_HI;
        default: p = CLS_ALPHA;
      endcase
    end else if (r == 6) begin
      p = PATTERN_W'($urandom_range(1, 31));
    end else if (r == 7) begin
      p = probe_chars[$urandom_range(0, 29)];
      if (p < LITERAL_BASE) begin
        p = LITERAL_BASE;
      end
    end else begin
      p = PATTERN_W'($urandom_range(32, 255));
    end
    return p;
  endfunction

  // Next states cluster on a few low states so that chains run long.
  function automatic int rand_next();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return probe_chars[$urandom_range(0, 29)];
    end else if (r < 7 && literal_bytes.size() > 0) begin
      return literal_bytes[$urandom_range(0, literal_bytes.size() - 1)];
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Driver: predicts each accepted transaction, then presents the next one
  // in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        lex_predict('{mode: mode_i, ch: char_in_i, st: entry_state_i,
                      sl: entry_slot_i, pat: entry_pattern_i,
                      act: entry_action_i, nxt: entry_next_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (lex_items_q.size() > 0) begin
          in_valid_i      <= 1'b1;
          mode_i          <= lex_items_q[0].mode;
          char_in_i       <= lex_items_q[0].ch;
          entry_state_i   <= lex_items_q[0].st;
          entry_slot_i    <= lex_items_q[0].sl;
          entry_pattern_i <= lex_items_q[0].pat;
          entry_action_i  <= lex_items_q[0].act;
          entry_next_i    <= lex_items_q[0].nxt;
          void'(lex_items_q.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the receiver stall
  // in one of four stall patterns, chosen at random.
  always @(posedge clk_i) begin
    lex_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lex_results_q.size() == 0) begin
        report_mismatch("result with no pending character transaction");
      end else begin
        want = lex_results_q.pop_front();
        if (action_out_o !== want.action) begin
          report_mismatch($sformatf("action_out %0d, predicted %0d",
                                    action_out_o, want.action));
        end
        if (next_state_out_o !== want.next) begin
          report_mismatch($sformatf("next_state_out %0d, predicted %0d",
                                    next_state_out_o, want.next));
        end
        if (error_flag_o !== want.err) begin
          report_mismatch($sformatf("error_flag %0b, predicted %0b",
                                    error_flag_o, want.err));
        end
      end
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 35);
      2:       out_stall_i <= ((cycle_cnt % 7) < 3);
      default: out_stall_i <= ((cycle_cnt % 24) < 14);
    endcase
    if (cycle_cnt % 250 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int st;
    int n_slots;
    int pick;
    for (int i = 0; i < NUM_STATES; i++) begin
      for (int j = 0; j < SLOTS_PER_STATE; j++) begin
        lex_table[i][j] = '0;
      end
    end
    lex_state = '0;

    // Directed part: empty state after reset, unused mode, list end,
    // literals, unassigned class, restart and field extremes.
    add_char("A");
    add_ctrl(MODE_UNUSED);
    add_load(0, 0, CLS_DIGIT, 15, 63);
    add_load(0, 1, 8'hFF, 10, 1);
    add_load(0, 3, "A", 3, 2);
    add_char("5");
    add_char("x");
    add_char(8'hFF);
    add_char(8'h00);
    add_char("A");
    add_load(0, 2, 8'd31, 1, 0);
    add_char("A");
    add_load(2, 0, CLS_BLANK, 0, 2);
    add_load(2, 1, CLS_LF, 10, 0);
    add_char(8'h09);
    add_ctrl(MODE_RESTART);
    add_char(8'h0A);
    add_load(63, 15, CLS_PRINT_HI, 15, 0);
    add_load(63, 0, CLS_CR, 5, 63);
    add_char("7");
    add_char(8'h0D);
    add_char(8'h80);

    // Random part: programmed states followed by character runs, plain
    // character runs, restarts, single slot rewrites and raw noise.
    while (stim_cnt < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        st      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
        n_slots = ($urandom_range(0, 9) == 0) ? SLOTS_PER_STATE : $urandom_range(0, 6);
        for (int k = 0; k < n_slots; k++) begin
          add_load(st, k, rand_pattern(), $urandom_range(0, 15), rand_next());
        end
        if (n_slots < SLOTS_PER_STATE) begin
          add_load(st, n_slots, PAT_END, $urandom_range(0, 15), $urandom_range(0, 63));
        end
        repeat ($urandom_range(3, 12)) add_char(rand_char());
      end else if (pick < 75) begin
        repeat ($urandom_range(4, 16)) add_char(rand_char());
      end else if (pick < 82) begin
        add_ctrl(MODE_RESTART);
        repeat ($urandom_range(1, 8)) add_char(rand_char());
      end else if (pick < 90) begin
        add_load(rand_next(), $urandom_range(0, 15), rand_pattern(), $urandom_range(0, 15),
                 rand_next());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_item(MODE_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                   STATE_W'($urandom_range(0, 63)), SLOT_W'($urandom_range(0, 15)),
                   PATTERN_W'($urandom_range(0, 255)), ACTION_W'($urandom_range(0, 15)),
                   NEXT_W'($urandom_range(0, 63)));
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to go in and every result to come out.
    while (lex_items_q.size() != 0 || in_valid_i || lex_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (lex_results_q.size() != 0) begin
      report_mismatch("predicted results never arrived");
    end
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cctf_pkg.sv
src/cctf_row_match.sv
src/char_class_table_fsm.sv
tb/tb_char_class_table_fsm.sv
